// ===== src/palette_pixel_scaler_3x_core_assert.svh =====
// Assertion macros for the checker file of the pixel scaler.
`ifndef PALETTE_PIXEL_SCALER_3X_CORE_ASSERT_SVH
`define PALETTE_PIXEL_SCALER_3X_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define PPS_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define PPS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

// Next-cycle implication that stays live through reset.
`define PPS_ASSERT_NEXT_ALWAYS(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/pps3x_pkg.sv =====
package pps3x_pkg;

    // Fixed address of the scanout copy of the framebuffer.
    localparam logic [31:0] SCANOUT_BASE = 32'h01C0_0000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Input word kinds.
    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_PIXEL   = 1'b1;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Geometry derived from the configuration, used by the front part.
    typedef struct packed {
        logic [12:0] dest_x;
        logic [12:0] dest_y;
        logic [12:0] width;
    } t_geom;

    // Configuration seen by the back part.
    typedef struct packed {
        logic [31:0] base;
        logic [13:0] stride2;
        logic        mirror;
    } t_bcfg;

    // One classified pixel: byte offset of its top-left write and its color.
    typedef struct packed {
        logic [31:0] offset;
        logic [15:0] color;
    } t_job;

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // Reset content of a palette entry: equal red, green and blue.
    function automatic logic [15:0] gray565(input logic [7:0] i);
        return pack565(i, i, i);
    endfunction

endpackage

// ===== src/palette_pixel_scaler_3x_core.sv =====
// Palette pixel scaler with 3x integer upscaling and RGB565 output.
//
// Input stream: each word is either a palette write (tuser[0] = 0), which
// packs red, green and blue into an RGB565 entry, or a source pixel
// (tuser[0] = 1) carrying a palette index; tuser[1] restarts the frame at
// column 0, row 0. Pixels arrive in raster order of the source frame.
// Output stream: every pixel becomes SCALE x SCALE framebuffer writes,
// centred on the configured screen, each word carrying a byte address and
// a color; tuser flags writes to the scanout copy and tlast marks the final
// write of a pixel. With screen_base away from the scanout address, each row
// of writes is repeated to the scanout copy, doubling the count.
// Throughput: one output word per cycle while the receiver does not stall,
// with the writes of one pixel and of the next leaving back to back; palette
// writes produce nothing. The single output channel sets that rate.
// A pixel passes front stages one and two, the queue, the back generator
// and the output register. The front runs ahead through a 4-entry queue,
// so input keeps flowing while the receiver stalls until the queue and
// the front stages hold 4 pixels. Reset clears the queue, the position
// and palette written marks, so each entry reads as its grayscale value.
module palette_pixel_scaler_3x_core #(
    parameter int SRC_WIDTH  = 320,
    parameter int SRC_HEIGHT = 200,
    parameter int SCALE      = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port: index 0 base, 1 width, 2 height.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: palette_index[7:0], red[15:8], green[23:16], blue[31:24],
    //        pixel_index[39:32]
    input  logic [39:0] i_s_tdata,
    // tuser: mode[0], frame_start[1]
    input  logic [1:0]  i_s_tuser,
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: write_address[31:0], color[47:32]
    output logic [47:0] o_m_tdata,
    // tuser: to_scanout[0]
    output logic [0:0]  o_m_tuser,
    output logic        o_m_tlast
);

    localparam logic [13:0] OUT_FRAME_W = 14'(SRC_WIDTH * SCALE);
    localparam logic [13:0] OUT_FRAME_H = 14'(SRC_HEIGHT * SCALE);

    logic [31:0] r_base;
    logic [12:0] r_width;
    logic [12:0] r_height;

    pps3x_pkg::t_geom w_geom;
    pps3x_pkg::t_bcfg w_bcfg;
    pps3x_pkg::t_job  w_push_job;
    pps3x_pkg::t_job  w_pop_job;
    logic             w_push;
    logic             w_pop;
    logic             w_nempty;
    logic [pps3x_pkg::FILL_W-1:0] w_fill;
    logic [13:0]      w_dx;
    logic [13:0]      w_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= pps3x_pkg::SCANOUT_BASE;
            r_width  <= 13'd1024;
            r_height <= 13'd768;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pps3x_pkg::CFG_BASE:   r_base   <= i_cfg_data;
                pps3x_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[12:0];
                pps3x_pkg::CFG_HEIGHT: r_height <= i_cfg_data[12:0];
                default:               r_base   <= r_base;
            endcase
        end
    end

    // Centring offsets: half the spare room, or zero when the screen is not
    // wider (taller) than the scaled frame.
    always_comb begin
        w_dx = ({1'b0, r_width} > OUT_FRAME_W) ? ({1'b0, r_width} - OUT_FRAME_W) >> 1 : '0;
        w_dy = ({1'b0, r_height} > OUT_FRAME_H) ? ({1'b0, r_height} - OUT_FRAME_H) >> 1 : '0;
        w_geom.dest_x  = w_dx[12:0];
        w_geom.dest_y  = w_dy[12:0];
        w_geom.width   = r_width;
        w_bcfg.base    = r_base;
        w_bcfg.stride2 = {r_width, 1'b0};
        w_bcfg.mirror  = (r_base != pps3x_pkg::SCANOUT_BASE);
    end

    pps3x_front #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .SCALE      (SCALE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (w_geom),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_fill     (w_fill),
        .o_push     (w_push),
        .o_push_job (w_push_job)
    );

    pps3x_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .i_pop      (w_pop),
        .o_pop_job  (w_pop_job),
        .o_nempty   (w_nempty),
        .o_fill     (w_fill)
    );

    pps3x_back #(
        .SCALE (SCALE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_bcfg),
        .i_q_nempty (w_nempty),
        .i_q_job    (w_pop_job),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== src/pps3x_queue.sv =====
module pps3x_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  pps3x_pkg::t_job             i_push_job,
    input  logic                        i_pop,
    output pps3x_pkg::t_job             o_pop_job,
    output logic                        o_nempty,
    output logic [pps3x_pkg::FILL_W-1:0] o_fill
);

    localparam int PW = (pps3x_pkg::QUEUE_DEPTH > 1) ? $clog2(pps3x_pkg::QUEUE_DEPTH) : 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(pps3x_pkg::QUEUE_DEPTH - 1);

    pps3x_pkg::t_job                 r_mem [pps3x_pkg::QUEUE_DEPTH];
    logic [PW-1:0]                   r_wr_ptr;
    logic [PW-1:0]                   r_rd_ptr;
    logic [pps3x_pkg::FILL_W-1:0]    r_fill;

    assign o_pop_job = r_mem[r_rd_ptr];
    assign o_nempty  = (r_fill != '0);
    assign o_fill    = r_fill;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// ===== src/pps3x_front.sv =====
module pps3x_front #(
    parameter int SRC_WIDTH  = 320,
    parameter int SRC_HEIGHT = 200,
    parameter int SCALE      = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pps3x_pkg::t_geom             i_geom,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [39:0]                  i_s_tdata,
    input  logic [1:0]                   i_s_tuser,
    input  logic [pps3x_pkg::FILL_W-1:0] i_fill,
    output logic                         o_push,
    output pps3x_pkg::t_job              o_push_job
);

    localparam int CW = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
    localparam int RW = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
    localparam logic [CW:0] COL_END = (CW + 1)'(SRC_WIDTH);
    localparam logic [RW:0] ROW_END = (RW + 1)'(SRC_HEIGHT);

    logic [15:0] r_pal_mem [256];
    logic [255:0] r_pal_vld;

    logic        w_accept;
    logic        w_mode;
    logic        w_frame_start;
    logic [7:0]  w_pal_idx;
    logic [7:0]  w_red;
    logic [7:0]  w_green;
    logic [7:0]  w_blue;
    logic [7:0]  w_pix_idx;
    logic [CW-1:0] w_col;
    logic [RW-1:0] w_row;
    logic [CW:0]   w_col_inc;
    logic [RW:0]   w_row_inc;
    logic [2:0]    w_inflight;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // Stage one: position taken, palette read issued.
    logic          r_s1_vld;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic [15:0]   r_s1_q;
    logic          r_s1_q_vld;
    logic [7:0]    r_s1_idx;

    // Stage two: row product and column offset.
    logic          r_s2_vld;
    logic [28:0]   r_s2_prod;
    logic [15:0]   r_s2_colx;
    logic [15:0]   r_s2_color;

    logic [15:0]   w_line0;
    logic [15:0]   w_colx;
    logic [28:0]   w_prod;
    logic [15:0]   w_color;
    logic [31:0]   w_pix0;

    assign w_pal_idx     = i_s_tdata[7:0];
    assign w_red         = i_s_tdata[15:8];
    assign w_green       = i_s_tdata[23:16];
    assign w_blue        = i_s_tdata[31:24];
    assign w_pix_idx     = i_s_tdata[39:32];
    assign w_mode        = i_s_tuser[0];
    assign w_frame_start = i_s_tuser[1];

    // A pixel word is taken only when the queue has a place reserved for it.
    assign w_inflight = 3'(i_fill) + {2'b00, r_s1_vld} + {2'b00, r_s2_vld};
    assign o_s_tready = (w_inflight < 3'(pps3x_pkg::QUEUE_DEPTH));
    assign w_accept   = i_s_tvalid & o_s_tready;

    always_comb begin
        w_col     = w_frame_start ? '0 : r_col;
        w_row     = w_frame_start ? '0 : r_row;
        w_col_inc = {1'b0, w_col} + 1'b1;
        w_row_inc = {1'b0, w_row} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_mode == pps3x_pkg::MODE_PALETTE)) begin
            r_pal_mem[w_pal_idx] <= pps3x_pkg::pack565(w_red, w_green, w_blue);
        end
        if (w_accept && (w_mode == pps3x_pkg::MODE_PIXEL)) begin
            r_s1_q <= r_pal_mem[w_pix_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
        end else begin
            r_s1_vld <= w_accept && (w_mode == pps3x_pkg::MODE_PIXEL);
            r_s2_vld <= r_s1_vld;
            if (w_accept && (w_mode == pps3x_pkg::MODE_PALETTE)) begin
                r_pal_vld[w_pal_idx] <= 1'b1;
            end
            if (w_accept && (w_mode == pps3x_pkg::MODE_PIXEL)) begin
                if (w_col_inc >= COL_END) begin
                    r_col <= '0;
                    r_row <= (w_row_inc >= ROW_END) ? '0 : w_row_inc[RW-1:0];
                end else begin
                    r_col <= w_col_inc[CW-1:0];
                    r_row <= w_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_mode == pps3x_pkg::MODE_PIXEL)) begin
            r_s1_col   <= w_col;
            r_s1_row   <= w_row;
            r_s1_q_vld <= r_pal_vld[w_pix_idx];
            r_s1_idx   <= w_pix_idx;
        end
    end

    always_comb begin
        w_line0 = 16'(i_geom.dest_y) + 16'(16'(r_s1_row) * 16'(SCALE));
        w_colx  = 16'(i_geom.dest_x) + 16'(16'(r_s1_col) * 16'(SCALE));
        w_prod  = {13'b0, w_line0} * {16'b0, i_geom.width};
        w_color = r_s1_q_vld ? r_s1_q : pps3x_pkg::gray565(r_s1_idx);
    end

    always_ff @(posedge i_clk) begin
        r_s2_prod  <= w_prod;
        r_s2_colx  <= w_colx;
        r_s2_color <= w_color;
    end

    assign w_pix0            = {3'b000, r_s2_prod} + {16'b0, r_s2_colx};
    assign o_push            = r_s2_vld;
    assign o_push_job.offset = {w_pix0[30:0], 1'b0};
    assign o_push_job.color  = r_s2_color;

endmodule

// ===== src/pps3x_back.sv =====
module pps3x_back #(
    parameter int SCALE = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pps3x_pkg::t_bcfg i_cfg,
    input  logic             i_q_nempty,
    input  pps3x_pkg::t_job  i_q_job,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [47:0]      o_m_tdata,
    output logic [0:0]       o_m_tuser,
    output logic             o_m_tlast
);

    localparam int SW = (SCALE > 1) ? $clog2(SCALE) : 1;
    localparam logic [SW-1:0] SUB_LAST = SW'(SCALE - 1);

    logic          r_busy;
    logic [SW-1:0] r_sx;
    logic [SW-1:0] r_sy;
    logic          r_pass;
    logic [31:0]   r_row_off;
    logic [31:0]   r_cur_off;
    logic [15:0]   r_color;

    logic          r_out_vld;
    logic [31:0]   r_out_addr;
    logic [15:0]   r_out_color;
    logic          r_out_scan;
    logic          r_out_last;

    logic          w_can_load;
    logic          w_gen;
    logic          w_last_sx;
    logic          w_last_pass;
    logic          w_last_w;
    logic [31:0]   w_next_row;

    always_comb begin
        w_can_load  = !r_out_vld || i_m_tready;
        w_gen       = r_busy && w_can_load;
        w_last_sx   = (r_sx == SUB_LAST);
        w_last_pass = r_pass || !i_cfg.mirror;
        w_last_w    = w_last_sx && w_last_pass && (r_sy == SUB_LAST);
        w_next_row  = r_row_off + {18'b0, i_cfg.stride2};
        o_pop       = i_q_nempty && (!r_busy || (w_gen && w_last_w));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
            r_sx      <= '0;
            r_sy      <= '0;
            r_pass    <= 1'b0;
        end else begin
            if (w_can_load) begin
                r_out_vld <= w_gen;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_sx   <= '0;
                r_sy   <= '0;
                r_pass <= 1'b0;
            end else if (w_gen) begin
                if (!w_last_sx) begin
                    r_sx <= r_sx + 1'b1;
                end else begin
                    r_sx <= '0;
                    if (!w_last_pass) begin
                        r_pass <= 1'b1;
                    end else begin
                        r_pass <= 1'b0;
                        r_sy   <= r_sy + 1'b1;
                    end
                end
                if (w_last_w) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_gen) begin
            r_out_addr  <= (r_pass ? pps3x_pkg::SCANOUT_BASE : i_cfg.base) + r_cur_off;
            r_out_color <= r_color;
            r_out_scan  <= r_pass;
            r_out_last  <= w_last_w;
        end
        if (o_pop) begin
            r_row_off <= i_q_job.offset;
            r_cur_off <= i_q_job.offset;
            r_color   <= i_q_job.color;
        end else if (w_gen) begin
            if (!w_last_sx) begin
                r_cur_off <= r_cur_off + 32'd2;
            end else if (!w_last_pass) begin
                r_cur_off <= r_row_off;
            end else begin
                r_row_off <= w_next_row;
                r_cur_off <= w_next_row;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_color, r_out_addr};
    assign o_m_tuser  = r_out_scan;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== src/pps3x_checker.sv =====
`include "palette_pixel_scaler_3x_core_assert.svh"

module pps3x_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic [0:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // Reset empties the output register.
    `PPS_ASSERT_NEXT_ALWAYS(a_reset_idle, !i_rst_n, !o_m_tvalid, "output valid after reset")

    // A stalled word holds.
    `PPS_ASSERT_NEXT(a_stall_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "stalled output word changed")

    // The writes of one pixel leave without gaps.
    `PPS_ASSERT_NEXT(a_no_gap, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tvalid, "gap inside the writes of a pixel")

    // All writes of one pixel carry the same color.
    `PPS_ASSERT_NEXT(a_same_color, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tdata[47:32] == $past(o_m_tdata[47:32]), "color changed inside a pixel")

endmodule

bind palette_pixel_scaler_3x_core pps3x_checker u_pps3x_checker (.*);
